### hdl/cbb_pkg.sv
package cbb_pkg;

    localparam int CBB_MAX_DIM = 4096;

    localparam int PIXEL_W    = 32;
    localparam int MODE_W     = 2;
    localparam int IMG_W_W    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int POS_W      = 12;
    localparam int SIZE_W     = 13;

    localparam logic [IMG_W_W-1:0] IMG_W_RESET = 13'd4096;

    typedef enum logic [0:0] {
        CFG_MARK_MODE   = 1'b0,
        CFG_IMAGE_WIDTH = 1'b1
    } t_cfg_reg;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALPHA = 2'd0,
        MODE_ANY   = 2'd1,
        MODE_DIFF  = 2'd2,
        MODE_DIFF3 = 2'd3
    } t_mark_mode;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [PIXEL_W-1:0] base_pixel;
        logic               end_of_frame;
    } t_in;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  left;
        logic [POS_W-1:0]  top;
        logic [SIZE_W-1:0] box_width;
        logic [SIZE_W-1:0] box_height;
    } t_out;

    // per-pixel control from the input stage to the tracker
    typedef struct packed {
        logic valid;
        logic marked;
        logic eof;
    } t_trk_ctl;

endpackage

### hdl/cbb_mark.sv
module cbb_mark
    import cbb_pkg::*;
(
    input  t_mark_mode         i_mode,
    input  logic [PIXEL_W-1:0] i_pixel,
    input  logic [PIXEL_W-1:0] i_base,
    output logic               o_marked
);

    logic [7:0] alpha_px;
    logic [7:0] alpha_base;
    logic       same;

    assign alpha_px   = i_pixel[31:24];
    assign alpha_base = i_base[31:24];

    // transparent pixels match regardless of color
    assign same = (alpha_px == alpha_base) &&
                  ((alpha_px == 8'd0) || (i_pixel[23:0] == i_base[23:0]));

    always_comb begin
        case (i_mode)
            MODE_ALPHA: o_marked = (alpha_px != 8'd0);
            MODE_ANY:   o_marked = (i_pixel != '0);
            default:    o_marked = !same;
        endcase
    end

endmodule

### hdl/cbb_tracker.sv
module cbb_tracker
    import cbb_pkg::*;
#(
    parameter int MAX_DIM = CBB_MAX_DIM
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [IMG_W_W-1:0] i_image_width,
    input  t_trk_ctl           i_ctl,
    output t_out               o_result
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int WW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
    localparam logic [CW-1:0] LAST = CW'(MAX_DIM - 1);

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] r_min_col, n_min_col;
    logic [CW-1:0] r_max_col, n_max_col;
    logic [CW-1:0] r_min_row, n_min_row;
    logic [CW-1:0] r_max_row, n_max_row;
    logic          r_any, n_any;

    logic [CW-1:0] upd_min_col, upd_max_col, upd_min_row, upd_max_row;
    logic          upd_any;
    logic [WW-1:0] width_ext;
    logic [WW-1:0] eff_width;
    logic [CW:0]   span_col, span_row;

    assign width_ext = WW'(i_image_width);
    assign eff_width = (width_ext == '0 || width_ext > WW'(MAX_DIM)) ? WW'(MAX_DIM) : width_ext;

    // fold the current pixel into the running box
    always_comb begin
        upd_min_col = r_min_col;
        upd_max_col = r_max_col;
        upd_min_row = r_min_row;
        upd_max_row = r_max_row;
        upd_any     = r_any;
        if (i_ctl.marked) begin
            if (r_col < r_min_col) upd_min_col = r_col;
            if (r_col > r_max_col) upd_max_col = r_col;
            if (r_row < r_min_row) upd_min_row = r_row;
            if (r_row > r_max_row) upd_max_row = r_row;
            upd_any = 1'b1;
        end
    end

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        n_any     = r_any;
        if (i_ctl.valid) begin
            if (i_ctl.eof) begin
                n_col     = '0;
                n_row     = '0;
                n_min_col = LAST;
                n_max_col = '0;
                n_min_row = LAST;
                n_max_row = '0;
                n_any     = 1'b0;
            end else begin
                n_min_col = upd_min_col;
                n_max_col = upd_max_col;
                n_min_row = upd_min_row;
                n_max_row = upd_max_row;
                n_any     = upd_any;
                if (WW'(r_col) + WW'(1) >= eff_width) begin
                    n_col = '0;
                    // saturate on the last row
                    if (r_row < LAST) n_row = r_row + CW'(1);
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_min_col <= LAST;
            r_max_col <= '0;
            r_min_row <= LAST;
            r_max_row <= '0;
            r_any     <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_min_col <= n_min_col;
            r_max_col <= n_max_col;
            r_min_row <= n_min_row;
            r_max_row <= n_max_row;
            r_any     <= n_any;
        end
    end

    assign span_col = {1'b0, upd_max_col} - {1'b0, upd_min_col} + (CW + 1)'(1);
    assign span_row = {1'b0, upd_max_row} - {1'b0, upd_min_row} + (CW + 1)'(1);

    always_comb begin
        o_result = '0;
        if (upd_any) begin
            o_result.found      = 1'b1;
            o_result.left       = POS_W'(upd_min_col);
            o_result.top        = POS_W'(upd_min_row);
            o_result.box_width  = SIZE_W'(span_col);
            o_result.box_height = SIZE_W'(span_row);
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_on_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.valid && i_ctl.eof) |=> (r_col == '0 && r_row == '0 && !r_any))
        else $error("frame state not cleared after end of frame");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> (r_min_col <= r_max_col && r_min_row <= r_max_row))
        else $error("bounding box min exceeds max");

    a_empty_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any |-> (r_min_col == LAST && r_max_col == '0 &&
                    r_min_row == LAST && r_max_row == '0))
        else $error("box bounds moved without a marked pixel");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_col) < eff_width || $past(i_image_width) != i_image_width)
        else $error("column counter beyond image width");
`endif

endmodule

### hdl/content_bounding_box.sv
// Bounding box of marked pixels. Pixels arrive in raster order, one request per
// clock, each with the base-image pixel at the same place; the column counter wraps
// at image_width and advances the row counter, which saturates at MAX_DIM-1. A pixel
// is marked by alpha nonzero (mode 0), any byte nonzero (mode 1) or by differing
// from the base pixel (modes 2 and 3). The request flagged end_of_frame is folded
// in, then one result (found, left, top, box_width, box_height) is issued and the
// frame state clears; a frame with nothing marked reports found=0 and zero fields.
// Throughput is one pixel per clock; the result register loads as the end-of-frame
// request leaves the input register. Input stall rises only while an end-of-frame
// pixel waits for the result register to drain. Write configuration between frames.
module content_bounding_box
    import cbb_pkg::*;
#(
    parameter int MAX_DIM = CBB_MAX_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  t_cfg_reg              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data
);

    t_mark_mode         r_mark_mode;
    logic [IMG_W_W-1:0] r_image_width;

    logic r_s1_valid, n_s1_valid;
    t_in  r_s1;
    logic r_out_valid, n_out_valid;
    t_out r_out;

    logic     in_accept;
    logic     out_free;
    logic     s1_proc;
    logic     marked;
    t_trk_ctl trk_ctl;
    t_out     result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_mode   <= MODE_ALPHA;
            r_image_width <= IMG_W_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MARK_MODE:   r_mark_mode   <= t_mark_mode'(i_cfg_data[MODE_W-1:0]);
                CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data[IMG_W_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free  = !r_out_valid || !i_out_stall;
    // an end-of-frame pixel holds until the result register can take its result
    assign s1_proc   = r_s1_valid && (!r_s1.end_of_frame || out_free);
    assign o_in_stall = r_s1_valid && !s1_proc;
    assign in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) n_s1_valid = 1'b1;
        else if (s1_proc) n_s1_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_in_data;
        end
    end

    cbb_mark u_mark (
        .i_mode   (r_mark_mode),
        .i_pixel  (r_s1.pixel),
        .i_base   (r_s1.base_pixel),
        .o_marked (marked)
    );

    assign trk_ctl.valid  = s1_proc;
    assign trk_ctl.marked = r_s1_valid && marked;
    assign trk_ctl.eof    = r_s1.end_of_frame;

    cbb_tracker #(
        .MAX_DIM (MAX_DIM)
    ) u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_image_width (r_image_width),
        .i_ctl         (trk_ctl),
        .o_result      (result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_proc && r_s1.end_of_frame) n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_proc && r_s1.end_of_frame) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_pixel_never_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1.end_of_frame) |-> !o_in_stall)
        else $error("ordinary pixel stalled the input");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s1.end_of_frame && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(s1_proc && r_s1.end_of_frame))
        else $error("result issued without an end-of-frame pixel");
`endif

endmodule

### tb/tb_content_bounding_box.sv
module tb_content_bounding_box;
    timeunit 1ns;
    timeprecision 1ps;

    import cbb_pkg::*;

    localparam int RANDOM_ITEMS = 930;
    localparam int DRAIN_CYCLES = 4;
    localparam int IDLE_LIMIT   = 2000;
    localparam int REPORT_LIMIT = 10;

    localparam t_out BOX_NONE   = '0;
    localparam t_out BOX_ORIGIN = '{found: 1'b1, left: '0, top: '0,
                                    box_width: 13'd1, box_height: 13'd1};

    typedef struct {
        t_mark_mode        mode;
        logic [IMG_W_W-1:0] width;
        t_in               req;
        bit                pinned;
        t_out              want;
    } t_script_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    t_cfg_reg              i_cfg_index = CFG_MARK_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    t_in                   i_in_data   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out                  o_out_data;

    // box tracker state and its copy of the registers
    t_mark_mode         mark_sel  = MODE_ALPHA;
    logic [IMG_W_W-1:0] width_reg = IMG_W_RESET;
    int unsigned col_pos, row_pos, col_lo, col_hi, row_lo, row_hi;
    bit          hit_seen;

    t_out        box_q[$];
    t_script_row script[$];
    int          fail_count  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    int          stall_style = 0;
    int          stall_left  = 0;
    int          stall_tick  = 0;

    content_bounding_box uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_frame();
        col_pos  = 0;
        row_pos  = 0;
        col_lo   = CBB_MAX_DIM - 1;
        col_hi   = 0;
        row_lo   = CBB_MAX_DIM - 1;
        row_hi   = 0;
        hit_seen = 1'b0;
    endfunction

    function automatic int unsigned effective_span();
        if (width_reg == 0 || width_reg > CBB_MAX_DIM) begin
            return CBB_MAX_DIM;
        end
        return width_reg;
    endfunction

    function automatic bit pixel_marked(logic [PIXEL_W-1:0] px, logic [PIXEL_W-1:0] base);
        if (mark_sel == MODE_DIFF || mark_sel == MODE_DIFF3) begin
            return !((px[31:24] == base[31:24]) &&
                     (px[31:24] == 8'h00 || px[23:0] == base[23:0]));
        end
        if (mark_sel == MODE_ANY) begin
            return px != '0;
        end
        return px[31:24] != 8'h00;
    endfunction

    function automatic void track_pixel(input t_in req, output bit has_box, output t_out box);
        int unsigned span;
        span    = effective_span();
        has_box = 1'b0;
        box     = '0;
        if (pixel_marked(req.pixel, req.base_pixel)) begin
            if (col_pos < col_lo) col_lo = col_pos;
            if (col_pos > col_hi) col_hi = col_pos;
            if (row_pos < row_lo) row_lo = row_pos;
            if (row_pos > row_hi) row_hi = row_pos;
            hit_seen = 1'b1;
        end
        if (!req.end_of_frame) begin
            if (col_pos + 1 >= span) begin
                col_pos = 0;
                // hold the last row once the frame runs past MAX_DIM rows
                if (row_pos < CBB_MAX_DIM - 1) row_pos++;
            end else begin
                col_pos++;
            end
            return;
        end
        has_box = 1'b1;
        if (hit_seen) begin
            box.found      = 1'b1;
            box.left       = POS_W'(col_lo);
            box.top        = POS_W'(row_lo);
            box.box_width  = SIZE_W'(col_hi - col_lo + 1);
            box.box_height = SIZE_W'(row_hi - row_lo + 1);
        end
        clear_frame();
    endfunction

    function automatic string box_text(t_out b);
        return $sformatf("found=%0d left=%0d top=%0d w=%0d h=%0d",
                         b.found, b.left, b.top, b.box_width, b.box_height);
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function automatic void add_row(t_mark_mode mode, logic [IMG_W_W-1:0] width,
                                    logic [PIXEL_W-1:0] px, logic [PIXEL_W-1:0] base,
                                    logic eof, bit pinned = 1'b0, t_out want = '0);
        t_script_row row;
        row.mode             = mode;
        row.width            = width;
        row.req.pixel        = px;
        row.req.base_pixel   = base;
        row.req.end_of_frame = eof;
        row.pinned           = pinned;
        row.want             = want;
        script.push_back(row);
    endfunction

    // density 0 leaves the frame empty, 4 is raw noise, the rest mark more and more pixels
    function automatic t_in random_pixel(int density);
        t_in req;
        bit  hit;
        req.pixel        = $urandom;
        req.base_pixel   = $urandom;
        req.end_of_frame = 1'b0;
        if ($urandom_range(0, 1) == 0) req.base_pixel[31:24] = 8'h00;
        if (density == 4) return req;
        case (density)
            0:       hit = 1'b0;
            1:       hit = ($urandom_range(0, 19) == 0);
            2:       hit = ($urandom_range(0, 3) == 0);
            default: hit = ($urandom_range(0, 1) == 0);
        endcase
        if (mark_sel == MODE_ALPHA) begin
            req.pixel[31:24] = hit ? 8'($urandom_range(1, 255)) : 8'h00;
        end else if (mark_sel == MODE_ANY) begin
            if (!hit) begin
                req.pixel = '0;
            end else if ($urandom_range(0, 1) == 0) begin
                req.pixel = 32'h1 << $urandom_range(0, 31);
            end else if (req.pixel == '0) begin
                req.pixel = 32'h1;
            end
        end else begin
            req.pixel = req.base_pixel;
            if (req.base_pixel[31:24] == 8'h00) begin
                // with both alphas zero the color bits do not matter
                if (hit) req.pixel[31:24] = 8'($urandom_range(1, 255));
                else     req.pixel[23:0]  = 24'($urandom);
            end else if (hit) begin
                req.pixel ^= 32'h1 << $urandom_range(0, 31);
            end
        end
        return req;
    endfunction

    task automatic send_request(input t_in req, input bit pinned, input t_out want);
        int   gap;
        bit   has_box;
        t_out box;
        track_pixel(req, has_box, box);
        if (has_box) box_q.push_back(pinned ? want : box);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drop valid and wait until every pending box is out and the pipe is quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (box_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setup(input t_mark_mode mode, input logic [IMG_W_W-1:0] width);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_MARK_MODE;
        i_cfg_data  <= CFG_DATA_W'(mode);
        @(posedge i_clk);
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= width;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        mark_sel  = mode;
        width_reg = width;
    endtask

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(20, 300);
        end else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_style)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 9) < 7);
            default: i_out_stall <= (stall_tick % 5 < 2);
        endcase
    end

    always @(posedge i_clk) begin : box_check
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (box_q.size() == 0) begin
                note_failure($sformatf("unexpected box: %s", box_text(o_out_data)));
            end else begin
                want = box_q.pop_front();
                if (want.found !== o_out_data.found || want.left !== o_out_data.left ||
                    want.top !== o_out_data.top ||
                    want.box_width !== o_out_data.box_width ||
                    want.box_height !== o_out_data.box_height) begin
                    note_failure($sformatf("box mismatch: expected %s, got %s",
                                           box_text(want), box_text(o_out_data)));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_in                req;
        t_mark_mode         mode_pick;
        logic [IMG_W_W-1:0] width_pick;
        int unsigned        span;
        int                 frame_len, density, n, frame_no, random_sent;

        clear_frame();
        frame_no    = 0;
        random_sent = 0;

        // single-pixel frames on the reset registers, then every mode
        add_row(MODE_ALPHA, 13'd4096, 32'hFF000000, 32'h00000000, 1'b1, 1'b1, BOX_ORIGIN);
        add_row(MODE_ALPHA, 13'd4096, 32'h00FFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, BOX_NONE);
        add_row(MODE_ANY,   13'd4096, 32'h00000001, 32'h00000000, 1'b1, 1'b1, BOX_ORIGIN);
        add_row(MODE_ANY,   13'd4096, 32'h00000000, 32'hFFFFFFFF, 1'b1, 1'b1, BOX_NONE);
        add_row(MODE_DIFF,  13'd4096, 32'h00123456, 32'h00ABCDEF, 1'b1, 1'b1, BOX_NONE);
        add_row(MODE_DIFF,  13'd4096, 32'hFFFFFFFF, 32'hFFFFFFFE, 1'b1, 1'b1, BOX_ORIGIN);
        add_row(MODE_DIFF,  13'd4096, 32'h01000000, 32'h00000000, 1'b1, 1'b1, BOX_ORIGIN);
        add_row(MODE_DIFF3, 13'd4096, 32'h80FFFFFF, 32'h80FFFFFF, 1'b1, 1'b1, BOX_NONE);
        add_row(MODE_DIFF3, 13'd4096, 32'h80000000, 32'h81000000, 1'b1, 1'b1, BOX_ORIGIN);
        // one column: every pixel starts a row
        add_row(MODE_ALPHA, 13'd1, 32'h00000000, 32'h0, 1'b0);
        add_row(MODE_ALPHA, 13'd1, 32'hFF000000, 32'h0, 1'b0);
        add_row(MODE_ALPHA, 13'd1, 32'h00000000, 32'h0, 1'b1, 1'b1,
                '{found: 1'b1, left: '0, top: 12'd1, box_width: 13'd1, box_height: 13'd1});
        // diagonal corners of a 2x2 frame
        add_row(MODE_ALPHA, 13'd2, 32'h00000000, 32'h0, 1'b0);
        add_row(MODE_ALPHA, 13'd2, 32'hFF000000, 32'h0, 1'b0);
        add_row(MODE_ALPHA, 13'd2, 32'h7F000000, 32'h0, 1'b0);
        add_row(MODE_ALPHA, 13'd2, 32'h00000000, 32'h0, 1'b1);
        // widths of zero and past the maximum fall back to MAX_DIM
        add_row(MODE_ALPHA, 13'd0, 32'h00FFFFFF, 32'h0, 1'b0);
        add_row(MODE_ALPHA, 13'd0, 32'h01000000, 32'h0, 1'b0);
        add_row(MODE_ALPHA, 13'd0, 32'hFF000000, 32'h0, 1'b1);
        add_row(MODE_ANY, 13'd8191, 32'h00000000, 32'h00000000, 1'b0);
        add_row(MODE_ANY, 13'd8191, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) begin
            if (script[k].mode != mark_sel || script[k].width != width_reg) begin
                settle();
                apply_setup(script[k].mode, script[k].width);
            end
            send_request(script[k].req, script[k].pinned, script[k].want);
        end

        while (random_sent < RANDOM_ITEMS) begin
            if (frame_no == 0 || $urandom_range(0, 2) == 0) begin
                mode_pick = t_mark_mode'($urandom_range(0, 3));
                case ($urandom_range(0, 9))
                    0:       width_pick = IMG_W_W'(CBB_MAX_DIM);
                    1:       width_pick = 13'd1;
                    2:       width_pick = IMG_W_W'($urandom_range(0, 8191));
                    default: width_pick = IMG_W_W'($urandom_range(2, 12));
                endcase
                settle();
                apply_setup(mode_pick, width_pick);
            end
            span = effective_span();
            // keep wide rows short: end those frames part way through the first row
            frame_len = (span > 64) ? $urandom_range(1, 40) : span * $urandom_range(1, 5);
            if ($urandom_range(0, 4) == 0) frame_len = $urandom_range(1, frame_len);
            density = $urandom_range(0, 4);
            for (n = 0; n < frame_len; n++) begin
                req = random_pixel(density);
                req.end_of_frame = (n == frame_len - 1);
                send_request(req, 1'b0, BOX_NONE);
            end
            random_sent += frame_len;
            frame_no++;
        end

        i_in_valid <= 1'b0;
        while (box_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && box_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/cbb_pkg.sv
hdl/cbb_mark.sv
hdl/cbb_tracker.sv
hdl/content_bounding_box.sv
tb/tb_content_bounding_box.sv
